// ===== rtl/sst_pkg.sv =====
// ----------------------------------------------------------------------------
// sst_pkg
// shared types and constants for the sorted score table
// ----------------------------------------------------------------------------
package sst_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [2:0] {
        ACT_INSERT   = 3'd0,
        ACT_DELETE   = 3'd1,
        ACT_LOWEST   = 3'd2,
        ACT_SAME     = 3'd3,
        ACT_BACKWARD = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOTHING   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_EMIT,
        S_WAIT
    } state_t;

    // datapath shift operation selectors
    typedef enum logic [1:0] {
        OP_NONE,
        OP_INS,
        OP_DEL
    } op_t;

    // controller to datapath
    typedef struct packed {
        logic          load;     // capture command
        logic          scan_clr; // reset scan pointer
        logic          scan_inc; // advance scan pointer
        logic          scan_dec; // step scan pointer back
        op_t           shift_op; // commit a table shift
        logic          emit;     // load output register
        logic [1:0]    emit_st;
        logic          emit_zero;
        logic          emit_last;
        logic          emit_cmd; // echo command key / score
    } ctrl_t;

    // datapath to controller
    typedef struct packed {
        action_t       act;
        logic          empty;
        logic          full;
        logic          scan_end;   // pointer at entry_count
        logic          key_hit;    // entry at pointer matches key
        logic          score_hit;  // entry at pointer has equal score
        logic          ins_here;   // insert position found at pointer
        logic          at_head;    // pointer is zero
        logic          out_busy;   // output register holds an item
        logic          found_any;  // same score matched at least once
    } stat_t;

endpackage

// ===== rtl/sorted_score_table.sv =====
// ----------------------------------------------------------------------------
// sorted_score_table
// bounded table of (key, score) entries kept in ascending score order
// ----------------------------------------------------------------------------
// lowest, full and unknown commands emit their result from S_SCAN;
//   insert and delete scan one entry per cycle while the output has room
// one item at a time, the next taken once the last result has left;
//   backward gives one result per cycle while the output has room, same
//   score emits each match from S_WAIT and then scans on from S_SHIFT
// reset: rst_n clears the entry count, sequencer and output valid at once
module sorted_score_table (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         action,
    input  logic [15:0]        key,
    input  logic signed [15:0] score,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        out_key,
    output logic signed [15:0] out_score,
    output logic [1:0]         status,
    output logic               last
);
    import sst_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    // datapath result stage, drained by the holding stage
    logic               dv;
    logic               dr;
    logic [15:0]        dk;
    logic signed [15:0] ds;
    logic [1:0]         dt;
    logic               dl;
    logic               closing;
    logic               core_ready;
    logic               in_take;
    logic               hold_busy;
    logic               hold_ready;
    logic               out_ready_hold;
    logic               hb_reg;

    // the sequencer only sees an item at the edge that accepts it
    assign in_take = in_valid && in_ready;

    sst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_take),
        .in_ready  (core_ready),
        .out_ready (dr),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    sst_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .action    (action),
        .key       (key),
        .score     (score),
        .ctrl      (ctrl),
        .stat      (stat),
        .out_valid (dv),
        .out_ready (dr),
        .out_key   (dk),
        .out_score (ds),
        .status    (dt),
        .last      (dl)
    );

    // a command closes once the sequencer is back in idle with the
    // datapath result stage empty; the held item then gets last
    assign closing  = core_ready && !dv;
    assign in_ready = closing && !hold_busy;

    sst_same u_hold (
        .clk       (clk),
        .rst_n     (rst_n),
        .d_valid   (dv),
        .d_ready   (hold_ready),
        .d_key     (dk),
        .d_score   (ds),
        .d_status  (dt),
        .d_last    (dl),
        .flush     (closing),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_key   (out_key),
        .out_score (out_score),
        .status    (status),
        .last      (last)
    );

    assign dr = hold_ready;

    // holding stage still owes an item of the previous command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hb_reg <= 1'b0;
        else if (dv && dr)
            hb_reg <= 1'b1;
        else if (closing && out_ready_hold)
            hb_reg <= 1'b0;
    end

    assign out_ready_hold = !out_valid || out_ready;
    assign hold_busy      = hb_reg || out_valid;

endmodule

// ===== rtl/sst_datapath.sv =====
// ----------------------------------------------------------------------------
// sst_datapath
// entry registers, scan pointer, shift network and output register
// ----------------------------------------------------------------------------
module sst_datapath (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [2:0]      action,
    input  logic [15:0]     key,
    input  logic signed [15:0] score,
    input  sst_pkg::ctrl_t  ctrl,
    output sst_pkg::stat_t  stat,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [15:0]     out_key,
    output logic signed [15:0] out_score,
    output logic [1:0]      status,
    output logic            last
);
    import sst_pkg::*;

    logic [15:0]        keys_reg   [TABLE_DEPTH];
    logic signed [15:0] scores_reg [TABLE_DEPTH];
    cnt_t               count_reg;
    cnt_t               ptr_reg;
    logic [2:0]         act_reg;
    logic [15:0]        key_reg;
    logic signed [15:0] score_reg;
    logic               found_reg;
    logic               ov_reg;
    logic [15:0]        ok_reg;
    logic signed [15:0] os_reg;
    logic [1:0]         st_reg;
    logic               last_reg;

    idx_t               pidx;
    logic               in_range;
    logic [15:0]        cur_key;
    logic signed [15:0] cur_score;

    assign pidx      = ptr_reg[IDX_W-1:0];
    assign in_range  = ptr_reg < count_reg;
    assign cur_key   = keys_reg[pidx];
    assign cur_score = scores_reg[pidx];

    always_comb
    begin
        stat.act       = action_t'(act_reg);
        stat.empty     = count_reg == '0;
        stat.full      = count_reg == cnt_t'(TABLE_DEPTH);
        stat.scan_end  = !in_range;
        stat.key_hit   = in_range && cur_key == key_reg;
        stat.score_hit = in_range && cur_score == score_reg;
        stat.ins_here  = !in_range || (ptr_reg == '0 ? score_reg < cur_score
                                                     : !(cur_score < score_reg));
        stat.at_head   = ptr_reg == '0;
        stat.out_busy  = ov_reg;
        stat.found_any = found_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ptr_reg   <= '0;
            ov_reg    <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.load)
                found_reg <= 1'b0;
            else if (ctrl.emit && ctrl.emit_st == ST_OK)
                found_reg <= 1'b1;
            if (ctrl.scan_clr)
                ptr_reg <= '0;
            else if (ctrl.scan_inc)
                ptr_reg <= ptr_reg + cnt_t'(1);
            else if (ctrl.scan_dec)
                ptr_reg <= ptr_reg - cnt_t'(1);
            if (ctrl.shift_op == OP_INS)
                count_reg <= count_reg + cnt_t'(1);
            else if (ctrl.shift_op == OP_DEL)
                count_reg <= count_reg - cnt_t'(1);
            if (ctrl.emit)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    // entry cells shift one place per commit
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            act_reg   <= action;
            key_reg   <= key;
            score_reg <= score;
        end
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (ctrl.shift_op == OP_INS)
            begin
                if (cnt_t'(i) == ptr_reg)
                begin
                    keys_reg[i]   <= key_reg;
                    scores_reg[i] <= score_reg;
                end
                else if (cnt_t'(i) > ptr_reg && i > 0)
                begin
                    keys_reg[i]   <= keys_reg[i-1];
                    scores_reg[i] <= scores_reg[i-1];
                end
            end
            else if (ctrl.shift_op == OP_DEL)
            begin
                if (cnt_t'(i) >= ptr_reg && i < TABLE_DEPTH - 1)
                begin
                    keys_reg[i]   <= keys_reg[i+1];
                    scores_reg[i] <= scores_reg[i+1];
                end
            end
        end
        if (ctrl.emit)
        begin
            st_reg   <= ctrl.emit_st;
            last_reg <= ctrl.emit_last;
            if (ctrl.emit_zero)
            begin
                ok_reg <= '0;
                os_reg <= '0;
            end
            else if (ctrl.emit_cmd)
            begin
                ok_reg <= key_reg;
                os_reg <= score_reg;
            end
            else
            begin
                ok_reg <= cur_key;
                os_reg <= cur_score;
            end
        end
    end

    assign out_valid = ov_reg;
    assign out_key   = ok_reg;
    assign out_score = os_reg;
    assign status    = st_reg;
    assign last      = last_reg;

endmodule

// ===== rtl/sst_ctrl.sv =====
// ----------------------------------------------------------------------------
// sst_ctrl
// command sequencer for the sorted score table
// ----------------------------------------------------------------------------
module sst_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            out_ready,
    input  sst_pkg::stat_t  stat,
    output sst_pkg::ctrl_t  ctrl
);
    import sst_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // room to emit when output is empty or being drained this cycle
    logic room;
    assign room = !stat.out_busy || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        ctrl           = '0;
        ctrl.shift_op  = OP_NONE;
        in_ready       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.load     = 1'b1;
                    ctrl.scan_clr = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (room)
                begin
                    unique case (stat.act)
                        ACT_INSERT:
                        begin
                            if (stat.full)
                            begin
                                ctrl.emit = 1'b1; ctrl.emit_st = ST_FULL;
                                ctrl.emit_zero = 1'b1; ctrl.emit_last = 1'b1;
                                state_next = S_IDLE;
                            end
                            else if (stat.ins_here)
                            begin
                                ctrl.shift_op = OP_INS;
                                ctrl.emit = 1'b1; ctrl.emit_st = ST_OK;
                                ctrl.emit_cmd = 1'b1; ctrl.emit_last = 1'b1;
                                state_next = S_IDLE;
                            end
                            else
                                ctrl.scan_inc = 1'b1;
                        end
                        ACT_DELETE, ACT_BACKWARD:
                        begin
                            if (stat.scan_end)
                            begin
                                ctrl.emit = 1'b1; ctrl.emit_st = ST_NOT_FOUND;
                                ctrl.emit_zero = 1'b1; ctrl.emit_last = 1'b1;
                                state_next = S_IDLE;
                            end
                            else if (stat.key_hit)
                            begin
                                if (stat.act == ACT_DELETE)
                                begin
                                    ctrl.emit = 1'b1; ctrl.emit_st = ST_OK;
                                    ctrl.emit_last = 1'b1;
                                    state_next = S_SHIFT;
                                end
                                else if (stat.at_head)
                                begin
                                    ctrl.emit = 1'b1; ctrl.emit_st = ST_NOTHING;
                                    ctrl.emit_zero = 1'b1; ctrl.emit_last = 1'b1;
                                    state_next = S_IDLE;
                                end
                                else
                                begin
                                    ctrl.scan_dec = 1'b1;
                                    state_next = S_EMIT;
                                end
                            end
                            else
                                ctrl.scan_inc = 1'b1;
                        end
                        ACT_LOWEST:
                        begin
                            ctrl.emit = 1'b1; ctrl.emit_last = 1'b1;
                            ctrl.emit_st = stat.empty ? ST_NOTHING : ST_OK;
                            ctrl.emit_zero = stat.empty;
                            state_next = S_IDLE;
                        end
                        ACT_SAME:
                        begin
                            if (stat.scan_end)
                            begin
                                if (!stat.found_any)
                                begin
                                    ctrl.emit = 1'b1; ctrl.emit_st = ST_NOTHING;
                                    ctrl.emit_zero = 1'b1; ctrl.emit_last = 1'b1;
                                end
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                if (stat.score_hit)
                                    state_next = S_WAIT;
                                else
                                    ctrl.scan_inc = 1'b1;
                            end
                        end
                        default:
                        begin
                            ctrl.emit = 1'b1; ctrl.emit_st = ST_NOTHING;
                            ctrl.emit_zero = 1'b1; ctrl.emit_last = 1'b1;
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_WAIT:
            begin
                // emit a same-score match; the holding stage adds last
                // once the scan runs off the end
                if (room)
                begin
                    ctrl.emit = 1'b1; ctrl.emit_st = ST_OK;
                    ctrl.scan_inc = 1'b1;
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                if (stat.act == ACT_DELETE)
                begin
                    ctrl.shift_op = OP_DEL;
                    state_next = S_IDLE;
                end
                else
                begin
                    // look for the next match before closing the command
                    if (stat.scan_end)
                        state_next = S_IDLE;
                    else if (stat.score_hit)
                        state_next = S_WAIT;
                    else
                        ctrl.scan_inc = 1'b1;
                end
            end
            S_EMIT:
            begin
                if (room)
                begin
                    ctrl.emit = 1'b1; ctrl.emit_st = ST_OK;
                    ctrl.emit_last = stat.at_head;
                    if (stat.at_head)
                        state_next = S_IDLE;
                    else
                        ctrl.scan_dec = 1'b1;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

// ===== rtl/sst_same.sv =====
// ----------------------------------------------------------------------------
// sst_same
// holds one result back until the next is known or the result is last
// ----------------------------------------------------------------------------
module sst_same (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            d_valid,
    output logic            d_ready,
    input  logic [15:0]     d_key,
    input  logic signed [15:0] d_score,
    input  logic [1:0]      d_status,
    input  logic            d_last,
    input  logic            flush,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [15:0]     out_key,
    output logic signed [15:0] out_score,
    output logic [1:0]      status,
    output logic            last
);
    // one-deep holding stage: an item is released when the next arrives or
    // when it carries last itself, else with last set when the command closes
    logic               hv_reg;
    logic [15:0]        hk_reg;
    logic signed [15:0] hs_reg;
    logic [1:0]         ht_reg;
    logic               hl_reg;
    logic               ov_reg;
    logic [15:0]        ok_reg;
    logic signed [15:0] os_reg;
    logic [1:0]         ot_reg;
    logic               ol_reg;
    logic               ofree;
    logic               push;
    logic               rel;

    assign ofree   = !ov_reg || out_ready;
    assign rel     = hv_reg && ofree && (d_valid || flush || hl_reg);
    assign d_ready = !hv_reg || rel;
    assign push    = d_valid && d_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (push)
                hv_reg <= 1'b1;
            else if (rel)
                hv_reg <= 1'b0;
            if (rel)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            hk_reg <= d_key;
            hs_reg <= d_score;
            ht_reg <= d_status;
            hl_reg <= d_last;
        end
        if (rel)
        begin
            ok_reg <= hk_reg;
            os_reg <= hs_reg;
            ot_reg <= ht_reg;
            ol_reg <= hl_reg || (flush && !d_valid);
        end
    end

    assign out_valid = ov_reg;
    assign out_key   = ok_reg;
    assign out_score = os_reg;
    assign status    = ot_reg;
    assign last      = ol_reg;

endmodule

// ===== rtl/sst_checker.sv =====
// ----------------------------------------------------------------------------
// sst_checker
// port-level checks for the sorted score table
// ----------------------------------------------------------------------------
module sst_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] out_key,
    input logic [15:0] out_score,
    input logic [1:0]  status,
    input logic        last
);
    import sst_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_key) && $stable(status))
        else $error("result changed while stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> out_key == '0 && out_score == '0 && last)
        else $error("error result not zero or not last");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item accepted while busy");

    a_idle_after_reset: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result shown during reset");

endmodule

bind sorted_score_table sst_checker u_sst_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_key   (out_key),
    .out_score (out_score),
    .status    (status),
    .last      (last)
);
